FILE: src/pfto_pkg.sv
// Shared types, constants and glyph ROM of the text overlay engine.
package pfto_pkg;

  localparam int unsigned FwW     = 13;
  localparam int unsigned AwW     = 10;
  localparam int unsigned AhW     = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CoordW  = 12;
  localparam int unsigned PixW    = 24;
  localparam int unsigned MaskW   = 15;
  localparam int unsigned GdimW   = 4;
  localparam int unsigned CodeW   = 7;
  localparam int unsigned RomAxW  = 9;
  localparam int unsigned RomAyW  = 7;
  localparam logic [7:0]  InkLimit = 8'd255;
  localparam logic [CoordW-1:0] PenMax = 12'd4095;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_ATLAS_WIDTH  = 2'd2,
    REG_ATLAS_HEIGHT = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [RomAxW-1:0] ax;
    logic [RomAyW-1:0] ay;
    logic [GdimW-1:0]  gw;
    logic [GdimW-1:0]  gh;
  } glyph_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture the draw item, look up glyph
    logic row_start; // begin a new row: compute row geometry
    logic col_step;  // sample one atlas bit into the mask
    logic emit;      // present the finished row
    logic pen_adv;   // advance the pen
  } pfto_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;     // glyph has no rows or no columns
    logic col_last;  // current column is the last one
    logic row_last;  // current row is the last one
  } pfto_sts_t;

  function automatic glyph_t glyph_lookup(input logic [CodeW-1:0] code);
    glyph_t g;
    g = '0;
    case (code)
      7'd32:  g = '{9'd81, 7'd5, 4'd6, 4'd11};
      7'd33:  g = '{9'd44, 7'd59, 4'd3, 4'd14};
      7'd34:  g = '{9'd243, 7'd59, 4'd5, 4'd14};
      7'd35:  g = '{9'd71, 7'd59, 4'd8, 4'd14};
      7'd36:  g = '{9'd84, 7'd59, 4'd6, 4'd14};
      7'd37:  g = '{9'd95, 7'd59, 4'd12, 4'd14};
      7'd38:  g = '{9'd125, 7'd59, 4'd11, 4'd14};
      7'd39:  g = '{9'd236, 7'd59, 4'd3, 4'd14};
      7'd42:  g = '{9'd141, 7'd59, 4'd7, 4'd14};
      7'd43:  g = '{9'd162, 7'd59, 4'd9, 4'd14};
      7'd44:  g = '{9'd9, 7'd59, 4'd4, 4'd14};
      7'd45:  g = '{9'd152, 7'd59, 4'd6, 4'd14};
      7'd46:  g = '{9'd0, 7'd59, 4'd3, 4'd14};
      7'd47:  g = '{9'd188, 7'd59, 4'd4, 4'd14};
      7'd48:  g = '{9'd2, 7'd5, 4'd7, 4'd11};
      7'd49:  g = '{9'd10, 7'd5, 4'd7, 4'd11};
      7'd50:  g = '{9'd18, 7'd5, 4'd7, 4'd11};
      7'd51:  g = '{9'd26, 7'd5, 4'd7, 4'd11};
      7'd52:  g = '{9'd33, 7'd5, 4'd7, 4'd11};
      7'd53:  g = '{9'd42, 7'd5, 4'd7, 4'd11};
      7'd54:  g = '{9'd50, 7'd5, 4'd7, 4'd11};
      7'd55:  g = '{9'd57, 7'd5, 4'd7, 4'd11};
      7'd56:  g = '{9'd66, 7'd5, 4'd7, 4'd11};
      7'd57:  g = '{9'd74, 7'd5, 4'd7, 4'd11};
      7'd58:  g = '{9'd25, 7'd59, 4'd3, 4'd14};
      7'd59:  g = '{9'd17, 7'd59, 4'd4, 4'd14};
      7'd61:  g = '{9'd175, 7'd59, 4'd9, 4'd14};
      7'd63:  g = '{9'd33, 7'd59, 4'd5, 4'd14};
      7'd64:  g = '{9'd53, 7'd59, 4'd14, 4'd15};
      7'd65:  g = '{9'd0, 7'd40, 4'd12, 4'd11};
      7'd66:  g = '{9'd16, 7'd40, 4'd9, 4'd11};
      7'd67:  g = '{9'd31, 7'd40, 4'd9, 4'd11};
      7'd68:  g = '{9'd45, 7'd40, 4'd10, 4'd11};
      7'd69:  g = '{9'd60, 7'd40, 4'd9, 4'd11};
      7'd70:  g = '{9'd73, 7'd40, 4'd8, 4'd11};
      7'd71:  g = '{9'd87, 7'd40, 4'd10, 4'd11};
      7'd72:  g = '{9'd101, 7'd40, 4'd11, 4'd11};
      7'd73:  g = '{9'd116, 7'd40, 4'd5, 4'd11};
      7'd74:  g = '{9'd125, 7'd40, 4'd6, 4'd11};
      7'd75:  g = '{9'd135, 7'd40, 4'd11, 4'd11};
      7'd76:  g = '{9'd151, 7'd40, 4'd9, 4'd11};
      7'd77:  g = '{9'd164, 7'd40, 4'd14, 4'd11};
      7'd78:  g = '{9'd182, 7'd40, 4'd12, 4'd11};
      7'd79:  g = '{9'd199, 7'd40, 4'd10, 4'd11};
      7'd80:  g = '{9'd214, 7'd40, 4'd8, 4'd11};
      7'd81:  g = '{9'd228, 7'd40, 4'd10, 4'd14};
      7'd82:  g = '{9'd243, 7'd40, 4'd10, 4'd11};
      7'd83:  g = '{9'd258, 7'd40, 4'd7, 4'd11};
      7'd84:  g = '{9'd270, 7'd40, 4'd9, 4'd11};
      7'd85:  g = '{9'd283, 7'd40, 4'd11, 4'd11};
      7'd86:  g = '{9'd298, 7'd40, 4'd11, 4'd11};
      7'd87:  g = '{9'd313, 7'd40, 4'd15, 4'd11};
      7'd88:  g = '{9'd332, 7'd40, 4'd11, 4'd11};
      7'd89:  g = '{9'd348, 7'd40, 4'd10, 4'd11};
      7'd90:  g = '{9'd362, 7'd40, 4'd9, 4'd11};
      7'd92:  g = '{9'd195, 7'd59, 4'd6, 4'd14};
      7'd94:  g = '{9'd112, 7'd59, 4'd8, 4'd14};
      7'd95:  g = '{9'd211, 7'd59, 4'd8, 4'd14};
      7'd97:  g = '{9'd2, 7'd21, 4'd6, 4'd14};
      7'd98:  g = '{9'd12, 7'd21, 4'd7, 4'd14};
      7'd99:  g = '{9'd25, 7'd21, 4'd5, 4'd14};
      7'd100: g = '{9'd36, 7'd21, 4'd7, 4'd14};
      7'd101: g = '{9'd48, 7'd21, 4'd5, 4'd14};
      7'd102: g = '{9'd58, 7'd21, 4'd6, 4'd14};
      7'd103: g = '{9'd66, 7'd21, 4'd7, 4'd14};
      7'd104: g = '{9'd77, 7'd21, 4'd7, 4'd14};
      7'd105: g = '{9'd88, 7'd21, 4'd3, 4'd14};
      7'd106: g = '{9'd94, 7'd21, 4'd4, 4'd14};
      7'd107: g = '{9'd103, 7'd21, 4'd8, 4'd14};
      7'd108: g = '{9'd115, 7'd21, 4'd4, 4'd14};
      7'd109: g = '{9'd122, 7'd21, 4'd11, 4'd14};
      7'd110: g = '{9'd137, 7'd21, 4'd7, 4'd14};
      7'd111: g = '{9'd149, 7'd21, 4'd6, 4'd14};
      7'd112: g = '{9'd160, 7'd21, 4'd7, 4'd14};
      7'd113: g = '{9'd173, 7'd21, 4'd7, 4'd14};
      7'd114: g = '{9'd184, 7'd21, 4'd5, 4'd14};
      7'd115: g = '{9'd194, 7'd21, 4'd4, 4'd14};
      7'd116: g = '{9'd203, 7'd21, 4'd4, 4'd14};
      7'd117: g = '{9'd211, 7'd21, 4'd7, 4'd14};
      7'd118: g = '{9'd222, 7'd21, 4'd7, 4'd14};
      7'd119: g = '{9'd233, 7'd21, 4'd11, 4'd14};
      7'd120: g = '{9'd248, 7'd21, 4'd9, 4'd14};
      7'd121: g = '{9'd259, 7'd21, 4'd7, 4'd14};
      7'd122: g = '{9'd270, 7'd21, 4'd6, 4'd14};
      7'd124: g = '{9'd204, 7'd59, 4'd3, 4'd15};
      7'd126: g = '{9'd223, 7'd59, 4'd9, 4'd14};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

FILE: src/pfto_ram.sv
// Generic RAM with one write port and one registered read port.
module pfto_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: src/pfto_ctrl.sv
// Sequencer for glyph rows and columns of one draw item.
module pfto_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                draw_i,
  input  pfto_pkg::pfto_sts_t sts_i,
  output pfto_pkg::pfto_cmd_t cmd_o,
  output logic                busy_o
);
  import pfto_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LOOK  = 6'b000010,
    ST_ROW   = 6'b000100,
    ST_COL   = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (draw_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (sts_i.empty) begin
          cmd_o.pen_adv = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_ROW;
        end
      end
      ST_ROW: begin
        cmd_o.row_start = 1'b1;
        state_d         = ST_COL;
      end
      ST_COL: begin
        // one atlas read issued per cycle; its data lands in the next cycle
        cmd_o.col_step = 1'b1;
        if (sts_i.col_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        if (sts_i.row_last) begin
          cmd_o.pen_adv = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          state_d = ST_ROW;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

`ifndef NO_ASSERTIONS
  a_emit_follows_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> $past(state_q == ST_DRAIN))
    else $error("row emitted without drain");
  a_load_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> !busy_o)
    else $error("load while busy");
  a_pen_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pen_adv |=> !busy_o)
    else $error("pen advanced mid-glyph");
`endif

endmodule

FILE: src/pfto_dp.sv
// Datapath: atlas store, glyph geometry, row mask build and pen.
module pfto_dp #(
  parameter int unsigned MaxFrameDim = 4096,
  parameter int unsigned AtlasDepth  = 65536,
  parameter int unsigned MaxGlyphDim = 15,
  parameter int unsigned GlyphCount  = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pfto_pkg::pfto_cmd_t          cmd_i,
  output pfto_pkg::pfto_sts_t          sts_o,
  input  logic                         wr_i,
  input  logic [15:0]                  atlas_address_i,
  input  logic [7:0]                   atlas_value_i,
  input  logic [pfto_pkg::CodeW-1:0]   char_code_i,
  input  logic                         new_string_i,
  input  logic [pfto_pkg::CoordW-1:0]  pos_x_i,
  input  logic [pfto_pkg::CoordW-1:0]  pos_y_i,
  input  logic [pfto_pkg::FwW-1:0]     frame_width_i,
  input  logic [pfto_pkg::FwW-1:0]     frame_height_i,
  input  logic [pfto_pkg::AwW-1:0]     atlas_width_i,
  input  logic [pfto_pkg::AhW-1:0]     atlas_height_i,
  output logic [pfto_pkg::PixW-1:0]    pixel_index_o,
  output logic [pfto_pkg::MaskW-1:0]   row_mask_o,
  output logic [pfto_pkg::GdimW-1:0]   glyph_width_o
);
  import pfto_pkg::*;

  localparam int unsigned AddrW = $clog2(AtlasDepth);
  localparam int unsigned GdimMax = (MaxGlyphDim < 15) ? MaxGlyphDim : 15;
  localparam logic [GdimW-1:0] GdimLim = GdimW'(GdimMax);
  // frame registers are 13 bits, so a limit above 8191 never clamps
  localparam logic [FwW-1:0] FrameLim = FwW'(MaxFrameDim < 8191 ? MaxFrameDim : 8191);

  // glyph lookup
  glyph_t g_raw;
  logic [GdimW-1:0] gw_c, gh_c;
  always_comb begin
    g_raw = glyph_lookup(char_code_i);
    if (32'(char_code_i) >= GlyphCount) g_raw = '0;
    gw_c = (g_raw.gw > GdimLim) ? GdimLim : g_raw.gw;
    gh_c = (g_raw.gh > GdimLim) ? GdimLim : g_raw.gh;
  end

  logic [RomAxW-1:0] ax_q;
  logic [RomAyW-1:0] ay_q;
  logic [GdimW-1:0]  gw_q, gh_q, row_q, col_q;
  logic [CoordW-1:0] pos_y_q, pen_q;
  logic [CoordW:0]   x0_q;
  logic [FwW-1:0]    fw_q, fh_q;

  // row geometry
  logic              row_ok_q;
  logic signed [FwW+1:0] oy_q;
  logic signed [AhW+1:0] ay_row_q;
  logic [MaskW-1:0]  mask_q;
  logic              smp_q;
  logic [GdimW-1:0]  smp_col_q;
  logic              rd_ok_q;

  // atlas column / address of the current column (ax-1+col)
  logic signed [RomAxW+1:0] acol;
  logic [AwW+AhW+1:0]       aidx;
  logic                     rd_ok;
  always_comb begin
    acol  = $signed({2'b0, ax_q}) - $signed((RomAxW+2)'(1)) +
            $signed({{(RomAxW-2){1'b0}}, col_q});
    aidx  = (AwW+AhW+2)'(acol[RomAxW:0]) +
            (AwW+AhW+2)'(atlas_width_i) * (AwW+AhW+2)'(ay_row_q[AhW-1:0]);
    rd_ok = row_ok_q && (acol >= 0) && (acol < $signed({2'b0, atlas_width_i})) &&
            (ay_row_q >= 0) && (ay_row_q < $signed({2'b0, atlas_height_i})) &&
            (32'(aidx) < AtlasDepth) &&
            (((CoordW+2)'(x0_q) + (CoordW+2)'(col_q)) < (CoordW+2)'(fw_q));
  end

  logic ink;
  pfto_ram #(.Width(1), .Depth(AtlasDepth)) u_atlas (
    .clk_i   (clk_i),
    .we_i    (wr_i && (32'(atlas_address_i) < AtlasDepth)),
    .waddr_i (AddrW'(atlas_address_i)),
    .wdata_i (atlas_value_i < InkLimit),
    .raddr_i (AddrW'(aidx)),
    .rdata_o (ink)
  );

  logic [12:0] pen_sum;
  assign pen_sum = 13'(pen_q) + 13'(gw_q) + 13'd1;

  logic [CoordW-1:0] pen_base;
  assign pen_base = new_string_i ? '0 : pen_q;

  logic signed [FwW+1:0] oy_c;
  assign oy_c = $signed({2'b0, fh_q}) -
                ($signed({2'b0, 1'b0, pos_y_q}) + $signed({{(FwW-2){1'b0}}, row_q}));

  logic [PixW+FwW:0] pix_c;
  assign pix_c = (PixW+FwW+1)'(x0_q) + (PixW+FwW+1)'(fw_q) * (PixW+FwW+1)'(oy_q[FwW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q <= '0;
    end else begin
      if (cmd_i.load && new_string_i) pen_q <= '0;
      if (cmd_i.pen_adv) pen_q <= (pen_sum > 13'(PenMax)) ? PenMax : pen_sum[CoordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    smp_q <= 1'b0;
    if (cmd_i.load) begin
      ax_q    <= g_raw.ax;
      ay_q    <= g_raw.ay;
      gw_q    <= gw_c;
      gh_q    <= gh_c;
      pos_y_q <= pos_y_i;
      x0_q    <= (CoordW+1)'(pos_x_i) + (CoordW+1)'(pen_base);
      fw_q    <= (frame_width_i > FrameLim) ? FrameLim : frame_width_i;
      fh_q    <= (frame_height_i > FrameLim) ? FrameLim : frame_height_i;
      row_q   <= '0;
    end
    if (cmd_i.row_start) begin
      oy_q     <= oy_c;
      ay_row_q <= $signed({2'b0, atlas_height_i}) -
                  ($signed({3'b0, ay_q}) + $signed({{(AhW-2){1'b0}}, row_q}));
      row_ok_q <= (oy_c >= 0) && (oy_c < $signed({2'b0, fh_q})) &&
                  (x0_q < (CoordW+1)'(fw_q));
      col_q    <= '0;
      mask_q   <= '0;
    end
    if (cmd_i.col_step) begin
      col_q     <= col_q + 1'b1;
      smp_q     <= 1'b1;
      smp_col_q <= col_q;
      rd_ok_q   <= rd_ok;
    end
    if (smp_q && rd_ok_q && ink) mask_q[smp_col_q] <= 1'b1;
    if (cmd_i.emit) begin
      row_q         <= row_q + 1'b1;
      pixel_index_o <= row_ok_q ? pix_c[PixW-1:0] : '0;
      row_mask_o    <= row_ok_q ? mask_q : '0;
      glyph_width_o <= gw_q;
    end
  end

  assign sts_o.empty    = (gw_q == '0) || (gh_q == '0);
  assign sts_o.col_last = (col_q == gw_q - 1'b1);
  assign sts_o.row_last = (row_q == gh_q - 1'b1);

`ifndef NO_ASSERTIONS
  a_pen_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pen_adv |=> pen_q >= $past(pen_q) || $past(cmd_i.load))
    else $error("pen went backwards");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.col_step |-> col_q < gw_q)
    else $error("column past glyph width");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> row_q < gh_q)
    else $error("row past glyph height");
`endif

endmodule

FILE: src/proportional_font_text_overlay_top.sv
// Top level of the proportional-font text overlay engine.
// A load beat (operation 0) stores one atlas ink bit; busy stays low.
// A draw beat (operation 1) keeps busy high while the glyph is drawn row by
// row (an empty glyph only advances the pen): the atlas has a single read
// port and is read one bit per cycle. One result per glyph row, top
// row first, appears for one cycle with result_valid_o; it cannot be stalled.
module proportional_font_text_overlay_top #(
  parameter int unsigned MAX_FRAME_DIM = 4096,
  parameter int unsigned ATLAS_DEPTH   = 65536,
  parameter int unsigned MAX_GLYPH_DIM = 15,
  parameter int unsigned GLYPH_COUNT   = 128
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [pfto_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pfto_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                          operation_i,
  input  logic [15:0]                   atlas_address_i,
  input  logic [7:0]                    atlas_value_i,
  input  logic [pfto_pkg::CodeW-1:0]    char_code_i,
  input  logic                          new_string_i,
  input  logic [pfto_pkg::CoordW-1:0]   pos_x_i,
  input  logic [pfto_pkg::CoordW-1:0]   pos_y_i,
  output logic                          result_valid_o,
  output logic [pfto_pkg::PixW-1:0]     pixel_index_o,
  output logic [pfto_pkg::MaskW-1:0]    row_mask_o,
  output logic [pfto_pkg::GdimW-1:0]    glyph_width_o,
  output logic                          last_o
);
  import pfto_pkg::*;

  logic [FwW-1:0] frame_width_q, frame_height_q;
  logic [AwW-1:0] atlas_width_q;
  logic [AhW-1:0] atlas_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd640;
      frame_height_q <= 13'd480;
      atlas_width_q  <= 10'd512;
      atlas_height_q <= 8'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i;
        REG_ATLAS_WIDTH:  atlas_width_q  <= cfg_data_i[AwW-1:0];
        REG_ATLAS_HEIGHT: atlas_height_q <= cfg_data_i[AhW-1:0];
        default: ;
      endcase
    end
  end

  logic      accept, ctl_busy;
  pfto_cmd_t cmd;
  pfto_sts_t sts;

  assign accept = start && !busy;
  assign busy   = ctl_busy;

  pfto_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .draw_i (accept && operation_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (ctl_busy)
  );

  pfto_dp #(
    .MaxFrameDim (MAX_FRAME_DIM),
    .AtlasDepth  (ATLAS_DEPTH),
    .MaxGlyphDim (MAX_GLYPH_DIM),
    .GlyphCount  (GLYPH_COUNT)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .wr_i            (accept && !operation_i),
    .atlas_address_i (atlas_address_i),
    .atlas_value_i   (atlas_value_i),
    .char_code_i     (char_code_i),
    .new_string_i    (new_string_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .frame_width_i   (frame_width_q),
    .frame_height_i  (frame_height_q),
    .atlas_width_i   (atlas_width_q),
    .atlas_height_i  (atlas_height_q),
    .pixel_index_o   (pixel_index_o),
    .row_mask_o      (row_mask_o),
    .glyph_width_o   (glyph_width_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_o <= 1'b0;
      last_o         <= 1'b0;
    end else begin
      result_valid_o <= cmd.emit;
      last_o         <= cmd.emit && sts.row_last;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy)
    else $error("non-final row while idle");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last without beat");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> !busy)
    else $error("busy after last row");
`endif

endmodule
